@@ hw/rtl/tqs_pkg.sv @@
// ----------------------------------------------------------------------------
// tqs_pkg: shared types and constants of the task queue scheduler
// slot sizes, task states, queue codes, opcodes, controller commands
// ----------------------------------------------------------------------------
package tqs_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int TASK_W     = 4;
  localparam int TIME_W     = 16;
  localparam int MASK_W     = 16;
  localparam int OP_W       = 3;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TIME_W-1:0] count_t;

  // task status codes
  localparam logic [1:0] ST_DEAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_BLOCK = 2'd3;

  // queue codes
  localparam logic [1:0] Q_RUN   = 2'd0;
  localparam logic [1:0] Q_WAIT  = 2'd1;
  localparam logic [1:0] Q_BLOCK = 2'd2;
  localparam logic [1:0] Q_NONE  = 2'd3;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd2;
  localparam logic [OP_W-1:0] OP_WAIT   = 3'd3;
  localparam logic [OP_W-1:0] OP_BLOCK  = 3'd4;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd5;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd6;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_DISPATCH,
    CMD_TICK,
    CMD_SELB,
    CMD_SELO,
    CMD_COMMIT,
    CMD_DETACH,
    CMD_SETUP,
    CMD_SORT,
    CMD_PUSH,
    CMD_ADD,
    CMD_DONE
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic cur_live;
    logic fin_ok;
    logic ready_now;
    logic wq_ne;
    logic bq_ne;
    logic last_w;
    logic last_b;
    logic mask_hit;
    logic other_w;
    logic other_r;
    logic sort_hit;
    logic add_hit;
    logic k_last;
    logic out_free;
  } stat_t;

  function automatic logic [1:0] queue_of(input logic [1:0] s);
    logic [1:0] q;
    case (s)
      ST_RUN:   q = Q_RUN;
      ST_WAIT:  q = Q_WAIT;
      ST_BLOCK: q = Q_BLOCK;
      default:  q = Q_NONE;
    endcase
    return q;
  endfunction

endpackage

@@ hw/rtl/tqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tqs_ctrl: scheduler sequencer
// one-hot state machine that steps the datapath through each operation
// ----------------------------------------------------------------------------
module tqs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  tqs_pkg::stat_t stat,
  output tqs_pkg::ctl_t  ctl
);
  import tqs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DISPATCH = 12'b000000000010,
    S_TICK     = 12'b000000000100,
    S_SELB     = 12'b000000001000,
    S_SELO     = 12'b000000010000,
    S_COMMIT   = 12'b000000100000,
    S_DETACH   = 12'b000001000000,
    S_SETUP    = 12'b000010000000,
    S_SORT     = 12'b000100000000,
    S_PUSH     = 12'b001000000000,
    S_ADD      = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.cmd    = CMD_IDLE;
    unique case (state)
      S_IDLE: begin
        ctl.load = s_tvalid;
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        ctl.cmd = CMD_DISPATCH;
        case (stat.op)
          OP_TICK:   state_next = stat.wq_ne ? S_TICK : S_DONE;
          OP_SELECT: state_next = stat.bq_ne ? S_SELB : S_SELO;
          OP_FINISH: state_next = stat.fin_ok ? S_PUSH : S_DONE;
          OP_WAIT:   state_next = stat.cur_live ? S_DETACH : S_DONE;
          OP_BLOCK:  state_next = (!stat.ready_now && stat.cur_live) ? S_DETACH : S_DONE;
          OP_ADD:    state_next = S_ADD;
          OP_REMOVE: state_next = S_DETACH;
          default:   state_next = S_DONE;
        endcase
      end
      S_TICK: begin
        ctl.cmd = CMD_TICK;
        if (stat.last_w) state_next = S_DONE;
      end
      S_SELB: begin
        ctl.cmd = CMD_SELB;
        if (stat.mask_hit) state_next = S_COMMIT;
        else if (stat.last_b) state_next = S_SELO;
      end
      S_SELO: begin
        ctl.cmd = CMD_SELO;
        state_next = (stat.other_w || stat.other_r) ? S_COMMIT : S_DONE;
      end
      S_COMMIT: begin
        ctl.cmd = CMD_COMMIT;
        state_next = S_DONE;
      end
      S_DETACH: begin
        ctl.cmd = CMD_DETACH;
        state_next = (stat.op == OP_REMOVE) ? S_DONE : S_SETUP;
      end
      S_SETUP: begin
        ctl.cmd = CMD_SETUP;
        state_next = (stat.op == OP_WAIT && stat.wq_ne) ? S_SORT : S_PUSH;
      end
      S_SORT: begin
        ctl.cmd = CMD_SORT;
        if (stat.sort_hit) state_next = S_DONE;
        else if (stat.last_w) state_next = S_PUSH;
      end
      S_PUSH: begin
        ctl.cmd = CMD_PUSH;
        state_next = S_DONE;
      end
      S_ADD: begin
        ctl.cmd = CMD_ADD;
        if (stat.add_hit) state_next = S_PUSH;
        else if (stat.k_last) state_next = S_DONE;
      end
      S_DONE: begin
        ctl.cmd = CMD_DONE;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/tqs_datapath.sv @@
// ----------------------------------------------------------------------------
// tqs_datapath: task tables, queue pointers and result register
// per-slot status, countdown and circular links, three linked queues
// ----------------------------------------------------------------------------
module tqs_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tqs_pkg::OP_W-1:0]  in_op,
  input  logic [tqs_pkg::IN_W-1:0]  in_data,
  input  tqs_pkg::ctl_t             ctl,
  output tqs_pkg::stat_t            stat,
  input  logic                      m_tready,
  output logic                      m_tvalid,
  output logic [tqs_pkg::OUT_W-1:0] m_tdata
);
  import tqs_pkg::*;

  logic [1:0] st_r   [TASK_SLOTS];
  count_t     cd     [TASK_SLOTS];
  slot_t      nx     [TASK_SLOTS];
  slot_t      pv     [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] queued;
  slot_t      qh     [3];
  slot_t      qt     [3];
  logic [2:0] qne;
  slot_t      cur;

  logic [OP_W-1:0]   op_r;
  logic [TASK_W-1:0] target_r;
  count_t            wt_r;
  logic              rdy_r;
  logic [MASK_W-1:0] mask_r;

  slot_t      c, id, k;
  logic [1:0] qsel;
  logic [TASK_W-1:0] chosen_r;
  logic       found_r, released_r;

  logic [1:0] uq;
  slot_t      p, n, ih, itl, pc;
  logic       do_unlink, do_push, do_insert;
  logic       hit_b;

  always_comb begin
    hit_b = 1'b0;
    if (32'(c) < MASK_W) hit_b = mask_r[TASK_W'(c)];
  end

  assign uq        = (ctl.cmd == CMD_COMMIT) ? qsel : queue_of(st_r[id]);
  assign p         = pv[id];
  assign n         = nx[id];
  assign ih        = qh[qsel];
  assign itl       = qt[qsel];
  assign pc        = pv[c];
  assign do_unlink = (ctl.cmd == CMD_COMMIT) || (ctl.cmd == CMD_DETACH && queued[id]);
  assign do_push   = (ctl.cmd == CMD_PUSH);
  assign do_insert = (ctl.cmd == CMD_SORT) && (cd[c] > cd[id]);

  always_comb begin
    stat.op        = op_r;
    stat.cur_live  = (st_r[cur] != ST_DEAD);
    stat.fin_ok    = (st_r[cur] == ST_RUN) && !queued[cur];
    stat.ready_now = rdy_r;
    stat.wq_ne     = qne[Q_WAIT];
    stat.bq_ne     = qne[Q_BLOCK];
    stat.last_w    = (c == qt[Q_WAIT]);
    stat.last_b    = (c == qt[Q_BLOCK]);
    stat.mask_hit  = hit_b;
    stat.other_w   = qne[Q_WAIT] && (cd[qh[Q_WAIT]] == '0);
    stat.other_r   = qne[Q_RUN];
    stat.sort_hit  = (cd[c] > cd[id]);
    stat.add_hit   = (st_r[k] == ST_DEAD);
    stat.k_last    = (32'(k) == TASK_SLOTS - 1);
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st_r[i] <= ST_DEAD;
        cd[i]   <= '0;
      end
      queued   <= '0;
      qne      <= '0;
      for (int j = 0; j < 3; j++) begin
        qh[j] <= '0;
        qt[j] <= '0;
      end
      cur      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.load) begin
        op_r       <= in_op;
        target_r   <= in_data[3:0];
        wt_r       <= in_data[19:4];
        rdy_r      <= in_data[20];
        mask_r     <= in_data[36:21];
        chosen_r   <= '0;
        found_r    <= 1'b0;
        released_r <= 1'b0;
      end

      if (m_tvalid && m_tready && !(ctl.cmd == CMD_DONE && stat.out_free)) m_tvalid <= 1'b0;

      // take a slot out of its queue
      if (do_unlink) begin
        if (qh[uq] == id && qt[uq] == id) begin
          qne[uq] <= 1'b0;
        end else begin
          nx[p] <= n;
          pv[n] <= p;
          if (qh[uq] == id) qh[uq] <= n;
          if (qt[uq] == id) qt[uq] <= p;
        end
        queued[id] <= 1'b0;
      end

      // append at the tail, ring closes back to the head
      if (do_push) begin
        if (!qne[qsel]) begin
          nx[id]    <= id;
          pv[id]    <= id;
          qh[qsel]  <= id;
          qt[qsel]  <= id;
          qne[qsel] <= 1'b1;
        end else begin
          nx[itl]  <= id;
          pv[id]   <= itl;
          nx[id]   <= ih;
          pv[ih]   <= id;
          qt[qsel] <= id;
        end
        queued[id] <= 1'b1;
      end

      // insert ahead of the first entry with a larger countdown
      if (do_insert) begin
        nx[pc]     <= id;
        pv[id]     <= pc;
        nx[id]     <= c;
        pv[c]      <= id;
        if (qh[Q_WAIT] == c) qh[Q_WAIT] <= id;
        queued[id] <= 1'b1;
      end

      case (ctl.cmd)
        CMD_DISPATCH: begin
          case (op_r)
            OP_TICK:   c <= qh[Q_WAIT];
            OP_SELECT: c <= qh[Q_BLOCK];
            OP_FINISH: begin
              id   <= cur;
              qsel <= Q_RUN;
            end
            OP_WAIT:   id <= cur;
            OP_BLOCK: begin
              id <= cur;
              if (rdy_r) released_r <= 1'b1;
            end
            OP_ADD:    k  <= '0;
            OP_REMOVE: id <= SLOT_W'(target_r);
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (cd[c] != '0) cd[c] <= cd[c] - 1'b1;
          c <= nx[c];
        end
        CMD_SELB: begin
          if (hit_b) begin
            id   <= c;
            qsel <= Q_BLOCK;
          end else begin
            c <= nx[c];
          end
        end
        CMD_SELO: begin
          if (stat.other_w) begin
            id   <= qh[Q_WAIT];
            qsel <= Q_WAIT;
          end else begin
            id   <= qh[Q_RUN];
            qsel <= Q_RUN;
          end
        end
        CMD_COMMIT: begin
          st_r[id] <= ST_RUN;
          cur      <= id;
          found_r  <= 1'b1;
          chosen_r <= TASK_W'(id);
        end
        CMD_DETACH: begin
          if (op_r == OP_REMOVE) st_r[id] <= ST_DEAD;
        end
        CMD_SETUP: begin
          if (op_r == OP_WAIT) begin
            cd[id]   <= wt_r;
            st_r[id] <= ST_WAIT;
            c        <= qh[Q_WAIT];
            qsel     <= Q_WAIT;
          end else begin
            st_r[id] <= ST_BLOCK;
            qsel     <= Q_BLOCK;
          end
        end
        CMD_SORT: begin
          if (!do_insert) c <= nx[c];
        end
        CMD_ADD: begin
          if (stat.add_hit) begin
            st_r[k]  <= ST_RUN;
            cd[k]    <= '0;
            id       <= k;
            qsel     <= Q_RUN;
            chosen_r <= TASK_W'(k);
            found_r  <= 1'b1;
          end else begin
            k <= k + 1'b1;
          end
        end
        CMD_DONE: begin
          if (stat.out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, released_r, found_r, chosen_r};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/task_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// task_queue_scheduler: cooperative task scheduler with three linked queues
// running fifo, countdown-sorted waiting queue and blocked fifo per slot
// ----------------------------------------------------------------------------
// channel  direction  payload
// s_*      in         tuser: op; tdata: target_task, wait_time, check_ready,
//                     ready_mask
// m_*      out        tdata: chosen_task, found, released
//
// one request at a time; the tick, the select over the blocked queue and the sorted
// insert walk one queue entry per cycle, and add scans one slot per cycle.
// reset clears all slots to dead and all queues to empty, no clearing pass.
// a result waits in the output register; a stalled m_tready holds the
// next result in the final state until the register frees.
module task_queue_scheduler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [2:0] op
  input  logic [tqs_pkg::OP_W-1:0]  s_tuser,
  // [3:0] target_task, [19:4] wait_time, [20] check_ready, [36:21] ready_mask
  input  logic [tqs_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [3:0] chosen_task, [4] found, [5] released
  output logic [tqs_pkg::OUT_W-1:0] m_tdata
);
  import tqs_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  tqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  tqs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_op    (s_tuser),
    .in_data  (s_tdata),
    .ctl      (ctl),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

@@ hw/rtl/tqs_checker.sv @@
// ----------------------------------------------------------------------------
// tqs_checker: port-level checks of the task queue scheduler
// handshake hold, one request in flight, result flag consistency
// ----------------------------------------------------------------------------
module tqs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [tqs_pkg::OUT_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
    else $error("found and released together");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind task_queue_scheduler tqs_checker u_tqs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb_task_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_task_queue_scheduler: self-checking bench of the task queue scheduler
// table-driven directed requests, then weighted random scheduler traffic,
// each response compared with a behavioral model of the three task queues
// ----------------------------------------------------------------------------
module tb_task_queue_scheduler;
  import tqs_pkg::*;

  localparam int NSLOT = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OP_W-1:0] s_tuser = '0;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  task_queue_scheduler u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic [3:0] chosen;
    logic       found;
    logic       released;
  } resp_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [3:0]      target;
    logic [15:0]     wtime;
    logic            rdy;
    logic [15:0]     mask;
    logic            has_exp;
    resp_t           exp;
  } req_row_t;

  // scheduler model state
  logic [1:0]  mdl_state [NSLOT];
  logic [15:0] mdl_count [NSLOT];
  logic [3:0]  mdl_next  [NSLOT];
  logic [3:0]  mdl_prev  [NSLOT];
  logic [3:0]  mdl_head  [3];
  logic [3:0]  mdl_tail  [3];
  logic        mdl_ne    [3];
  logic [3:0]  mdl_cur;

  resp_t resp_q[$];
  int    errors = 0;
  bit    quiet = 0;

  function automatic int qidx(logic [1:0] q);
    return int'(q);
  endfunction

  function automatic bit is_queued(logic [1:0] q, logic [3:0] id);
    logic [3:0] c;
    if (q == Q_NONE || !mdl_ne[qidx(q)]) return 0;
    c = mdl_head[qidx(q)];
    for (int k = 0; k < NSLOT; k++) begin
      if (c == id) return 1;
      if (c == mdl_tail[qidx(q)]) break;
      c = mdl_next[c];
    end
    return 0;
  endfunction

  task automatic unlink(logic [1:0] q, logic [3:0] id);
    logic [3:0] p, n;
    p = mdl_prev[id];
    n = mdl_next[id];
    if (mdl_head[qidx(q)] == id && mdl_tail[qidx(q)] == id) begin
      mdl_ne[qidx(q)] = 0;
      return;
    end
    mdl_next[p] = n;
    mdl_prev[n] = p;
    if (mdl_head[qidx(q)] == id) mdl_head[qidx(q)] = n;
    if (mdl_tail[qidx(q)] == id) mdl_tail[qidx(q)] = p;
  endtask

  task automatic append(logic [1:0] q, logic [3:0] id);
    logic [3:0] h, t;
    h = mdl_head[qidx(q)];
    t = mdl_tail[qidx(q)];
    if (!mdl_ne[qidx(q)]) begin
      mdl_next[id] = id; mdl_prev[id] = id;
      mdl_head[qidx(q)] = id; mdl_tail[qidx(q)] = id;
      mdl_ne[qidx(q)] = 1;
      return;
    end
    mdl_next[t] = id; mdl_prev[id] = t;
    mdl_next[id] = h; mdl_prev[h] = id;
    mdl_tail[qidx(q)] = id;
  endtask

  // ties go after equal countdowns
  task automatic insert_sorted(logic [3:0] id);
    logic [3:0] c, p;
    if (!mdl_ne[Q_WAIT]) begin
      append(Q_WAIT, id);
      return;
    end
    c = mdl_head[Q_WAIT];
    for (int k = 0; k < NSLOT; k++) begin
      if (mdl_count[c] > mdl_count[id]) begin
        p = mdl_prev[c];
        mdl_next[p] = id; mdl_prev[id] = p;
        mdl_next[id] = c; mdl_prev[c] = id;
        if (mdl_head[Q_WAIT] == c) mdl_head[Q_WAIT] = id;
        return;
      end
      if (c == mdl_tail[Q_WAIT]) break;
      c = mdl_next[c];
    end
    append(Q_WAIT, id);
  endtask

  task automatic detach_slot(logic [3:0] id);
    logic [1:0] q;
    q = queue_of(mdl_state[id]);
    if (is_queued(q, id)) unlink(q, id);
  endtask

  task automatic sched_reset();
    for (int i = 0; i < NSLOT; i++) begin
      mdl_state[i] = ST_DEAD; mdl_count[i] = '0;
      mdl_next[i] = '0; mdl_prev[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      mdl_head[i] = '0; mdl_tail[i] = '0; mdl_ne[i] = 0;
    end
    mdl_cur = '0;
  endtask

  task automatic sched_step(input req_row_t r, output resp_t res);
    logic [3:0] c;
    logic [1:0] q;
    bit live;
    res = '0;
    live = mdl_state[mdl_cur] != ST_DEAD;
    case (r.op)
      OP_TICK: if (mdl_ne[Q_WAIT]) begin
        c = mdl_head[Q_WAIT];
        for (int k = 0; k < NSLOT; k++) begin
          if (mdl_count[c] != 0) mdl_count[c]--;
          if (c == mdl_tail[Q_WAIT]) break;
          c = mdl_next[c];
        end
      end
      OP_SELECT: begin
        q = Q_NONE;
        if (mdl_ne[Q_BLOCK]) begin
          c = mdl_head[Q_BLOCK];
          for (int k = 0; k < NSLOT; k++) begin
            if (r.mask[c]) begin q = Q_BLOCK; res.chosen = c; break; end
            if (c == mdl_tail[Q_BLOCK]) break;
            c = mdl_next[c];
          end
        end
        if (q == Q_NONE && mdl_ne[Q_WAIT] && mdl_count[mdl_head[Q_WAIT]] == 0) begin
          q = Q_WAIT; res.chosen = mdl_head[Q_WAIT];
        end
        if (q == Q_NONE && mdl_ne[Q_RUN]) begin
          q = Q_RUN; res.chosen = mdl_head[Q_RUN];
        end
        if (q != Q_NONE) begin
          unlink(q, res.chosen);
          mdl_state[res.chosen] = ST_RUN;
          mdl_cur = res.chosen;
          res.found = 1;
        end
      end
      OP_FINISH:
        if (live && mdl_state[mdl_cur] == ST_RUN && !is_queued(Q_RUN, mdl_cur))
          append(Q_RUN, mdl_cur);
      OP_WAIT: if (live) begin
        detach_slot(mdl_cur);
        mdl_count[mdl_cur] = r.wtime;
        mdl_state[mdl_cur] = ST_WAIT;
        insert_sorted(mdl_cur);
      end
      OP_BLOCK:
        if (r.rdy) res.released = 1;
        else if (live) begin
          detach_slot(mdl_cur);
          mdl_state[mdl_cur] = ST_BLOCK;
          append(Q_BLOCK, mdl_cur);
        end
      OP_ADD:
        for (int k = 0; k < NSLOT; k++) begin
          if (mdl_state[k] == ST_DEAD) begin
            mdl_state[k] = ST_RUN;
            mdl_count[k] = '0;
            append(Q_RUN, 4'(k));
            res.chosen = 4'(k);
            res.found = 1;
            break;
          end
        end
      OP_REMOVE: begin
        detach_slot(r.target);
        mdl_state[r.target] = ST_DEAD;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // request side
  task automatic send(input req_row_t r);
    resp_t res;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sched_step(r, res);
    if (r.has_exp && res != r.exp) begin
      report_mismatch("directed row vs model", res, r.exp);
      res = r.exp;
    end
    resp_q.push_back(res);
    s_tuser <= r.op;
    s_tdata <= {3'b0, r.mask, r.rdy, r.wtime, r.target};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic req_row_t mk(logic [OP_W-1:0] op, logic [3:0] t, logic [15:0] w,
                                  logic rd, logic [15:0] m);
    req_row_t r;
    r.op = op; r.target = t; r.wtime = w; r.rdy = rd; r.mask = m;
    r.has_exp = 0; r.exp = '0;
    return r;
  endfunction

  function automatic req_row_t mkx(logic [OP_W-1:0] op, logic [3:0] t, logic [15:0] w,
                                   logic rd, logic [15:0] m, resp_t e);
    req_row_t r;
    r = mk(op, t, w, rd, m);
    r.has_exp = 1; r.exp = e;
    return r;
  endfunction

  // response side
  always @(posedge clk) begin
    resp_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.chosen   = m_tdata[3:0];
      got.found    = m_tdata[4];
      got.released = m_tdata[5];
      if (resp_q.size() == 0) report_mismatch("unexpected response", got, 0);
      else begin
        want = resp_q.pop_front();
        if (got.chosen != want.chosen) report_mismatch("chosen_task", got.chosen, want.chosen);
        if (got.found != want.found) report_mismatch("found", got.found, want.found);
        if (got.released != want.released)
          report_mismatch("released", got.released, want.released);
      end
    end
  end

  // response backpressure in bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 9);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    req_row_t dir[$];
    req_row_t r;
    int ops, live_est;
    sched_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir.push_back(mkx(OP_SELECT, 0, 0, 0, 16'hFFFF, '{4'd0, 1'b0, 1'b0}));
    dir.push_back(mkx(OP_WAIT, 0, 16'hFFFF, 0, 0, '{4'd0, 1'b0, 1'b0}));
    dir.push_back(mkx(OP_BLOCK, 0, 0, 1, 0, '{4'd0, 1'b0, 1'b1}));
    dir.push_back(mkx(OP_BLOCK, 0, 0, 0, 0, '{4'd0, 1'b0, 1'b0}));
    dir.push_back(mkx(OP_FINISH, 0, 0, 0, 0, '{4'd0, 1'b0, 1'b0}));
    dir.push_back(mkx(OP_REMOVE, 4'hF, 0, 0, 0, '{4'd0, 1'b0, 1'b0}));
    dir.push_back(mkx(3'd7, 4'hF, 16'hFFFF, 1, 16'hFFFF, '{4'd0, 1'b0, 1'b0}));
    dir.push_back(mkx(OP_ADD, 0, 0, 0, 0, '{4'd0, 1'b1, 1'b0}));
    dir.push_back(mkx(OP_ADD, 0, 0, 0, 0, '{4'd1, 1'b1, 1'b0}));
    dir.push_back(mkx(OP_ADD, 0, 0, 0, 0, '{4'd2, 1'b1, 1'b0}));
    dir.push_back(mk(OP_SELECT, 0, 0, 0, 0));
    dir.push_back(mk(OP_WAIT, 0, 16'd2, 0, 0));
    dir.push_back(mk(OP_SELECT, 0, 0, 0, 0));
    dir.push_back(mk(OP_WAIT, 0, 16'd2, 0, 0));
    dir.push_back(mk(OP_SELECT, 0, 0, 0, 0));
    dir.push_back(mk(OP_BLOCK, 0, 0, 0, 0));
    dir.push_back(mk(OP_TICK, 0, 0, 0, 0));
    dir.push_back(mk(OP_TICK, 0, 0, 0, 0));
    dir.push_back(mk(OP_SELECT, 0, 0, 0, 16'h0000));
    dir.push_back(mk(OP_SELECT, 0, 0, 0, 16'h0004));
    dir.push_back(mk(OP_FINISH, 0, 0, 0, 0));
    dir.push_back(mk(OP_FINISH, 0, 0, 0, 0));
    dir.push_back(mk(OP_REMOVE, 4'd1, 0, 0, 0));
    dir.push_back(mk(OP_REMOVE, 4'd1, 0, 0, 0));
    dir.push_back(mk(OP_WAIT, 0, 16'd0, 0, 0));
    foreach (dir[i]) send(dir[i]);

    for (int i = 0; i < 850; i++) begin
      if (i > 780) quiet = 1;
      live_est = 0;
      for (int k = 0; k < NSLOT; k++) if (mdl_state[k] != ST_DEAD) live_est++;
      ops = $urandom_range(0, 99);
      // keep the slot pool busy so queues grow deep, with some removals
      if (live_est < 6 && ops < 40) ops = 85;
      r.op = ops < 15 ? OP_TICK : ops < 38 ? OP_SELECT : ops < 50 ? OP_FINISH :
             ops < 65 ? OP_WAIT : ops < 78 ? OP_BLOCK : ops < 90 ? OP_ADD :
             ops < 98 ? OP_REMOVE : 3'd7;
      r.target = 4'($urandom_range(0, 15));
      r.wtime = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      r.rdy = $urandom_range(0, 3) == 0;
      r.mask = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'(1 << $urandom_range(0, 15));
      r.has_exp = 0; r.exp = '0;
      send(r);
    end
    s_tvalid <= 1'b0;

    while (resp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/tqs_pkg.sv
hw/rtl/tqs_ctrl.sv
hw/rtl/tqs_datapath.sv
hw/rtl/task_queue_scheduler.sv
hw/rtl/tqs_checker.sv
dv/tb_task_queue_scheduler.sv
